[design/rgb565_tile_untiler_unit_macros.svh]
// ----------------------------------------------------------------------------
// rgb565 tile untiler assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef RGB565_TILE_UNTILER_UNIT_MACROS_SVH
`define RGB565_TILE_UNTILER_UNIT_MACROS_SVH

// same-cycle implication
`define RTU_CHECK_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTU_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/rtu_pkg.sv]
// ----------------------------------------------------------------------------
// rtu_pkg
// widths, register indexes, shared types and colour expansion helpers
// ----------------------------------------------------------------------------
package rtu_pkg;

	localparam int DIM_W     = 13;
	localparam int POS_W     = 12;
	localparam int PIX_W     = 16;
	localparam int CH_W      = 8;
	localparam int CFG_IDX_W = 8;

	localparam int MAX_DIM   = 4096;
	localparam int LIMIT_I   = (MAX_DIM < 4096) ? MAX_DIM : 4096;

	localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(LIMIT_I);
	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(4);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} dims_t;

	typedef struct packed {
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last;
	} pos_t;

	// zero reads as one, large values saturate
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
		logic [DIM_W-1:0] d;
		d = (raw == '0) ? DIM_W'(1) : raw;
		if (d > DIM_LIMIT) begin
			d = DIM_LIMIT;
		end
		return d;
	endfunction

	function automatic logic [CH_W-1:0] expand5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [CH_W-1:0] expand6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

endpackage

[design/rtu_cfg.sv]
// ----------------------------------------------------------------------------
// rtu_cfg
// image size registers, stored already clamped to the usable range
// ----------------------------------------------------------------------------
module rtu_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rtu_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [rtu_pkg::DIM_W-1:0]     wr_data,
	output rtu_pkg::dims_t                dims
);
	import rtu_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (wr_en) begin
			priority if (wr_index == REG_IMAGE_WIDTH) begin
				width_q <= eff_dim(wr_data);
			end else if (wr_index == REG_IMAGE_HEIGHT) begin
				height_q <= eff_dim(wr_data);
			end else begin
				width_q <= width_q;
			end
		end
	end

	assign dims.width  = width_q;
	assign dims.height = height_q;

endmodule

[design/rtu_pos.sv]
// ----------------------------------------------------------------------------
// rtu_pos
// tile walk counters: current destination position and advance on each request
// ----------------------------------------------------------------------------
module rtu_pos (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  rtu_pkg::dims_t dims,
	output rtu_pkg::pos_t  cur
);
	import rtu_pkg::*;

	logic [POS_W-1:0] org_col_q, org_row_q;
	logic [1:0]       sub_col_q, sub_row_q;

	logic [POS_W-1:0] cur_oc, cur_or, nxt_oc, nxt_or;
	logic [1:0]       cur_sc, cur_sr, nxt_sc, nxt_sr;
	logic [DIM_W-1:0] col_raw, row_raw;
	logic [2:0]       nc, nr;
	logic             outside, col_step, row_step, tcol_step, trow_step, last;

	always_comb begin
		col_raw = {1'b0, org_col_q} + DIM_W'(sub_col_q);
		row_raw = {1'b0, org_row_q} + DIM_W'(sub_row_q);
		outside = (col_raw >= dims.width) || (row_raw >= dims.height);

		cur_oc = outside ? '0 : org_col_q;
		cur_or = outside ? '0 : org_row_q;
		cur_sc = outside ? '0 : sub_col_q;
		cur_sr = outside ? '0 : sub_row_q;

		nc = {1'b0, cur_sc} + 3'd1;
		nr = {1'b0, cur_sr} + 3'd1;
		col_step  = (cur_sc != 2'd3) && (({1'b0, cur_oc} + DIM_W'(nc)) < dims.width);
		row_step  = (cur_sr != 2'd3) && (({1'b0, cur_or} + DIM_W'(nr)) < dims.height);
		tcol_step = ({1'b0, cur_oc} + DIM_W'(4)) < dims.width;
		trow_step = ({1'b0, cur_or} + DIM_W'(4)) < dims.height;

		nxt_oc = cur_oc;
		nxt_or = cur_or;
		nxt_sc = cur_sc;
		nxt_sr = cur_sr;
		last   = 1'b0;
		if (col_step) begin
			nxt_sc = nc[1:0];
		end else begin
			nxt_sc = '0;
			if (row_step) begin
				nxt_sr = nr[1:0];
			end else begin
				nxt_sr = '0;
				if (tcol_step) begin
					nxt_oc = cur_oc + POS_W'(4);
				end else begin
					nxt_oc = '0;
					if (trow_step) begin
						nxt_or = cur_or + POS_W'(4);
					end else begin
						nxt_or = '0;
						last   = 1'b1;
					end
				end
			end
		end

		cur.column = outside ? '0 : col_raw[POS_W-1:0];
		cur.row    = outside ? '0 : row_raw[POS_W-1:0];
		cur.last   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_col_q <= '0;
			org_row_q <= '0;
			sub_col_q <= '0;
			sub_row_q <= '0;
		end else if (adv) begin
			org_col_q <= nxt_oc;
			org_row_q <= nxt_or;
			sub_col_q <= nxt_sc;
			sub_row_q <= nxt_sr;
		end
	end

endmodule

[design/rgb565_tile_untiler_unit.sv]
// ----------------------------------------------------------------------------
// rgb565_tile_untiler_unit
// an accepted pixel word passes through the input register, then the result register, to the outputs
// throughput: one request per cycle while out_ready is high, set by the input and result registers
// the position counters advance as a request moves into the result register
// reset clears both pipeline stages and the counters, image size returns to 4x4
// ----------------------------------------------------------------------------
`include "rgb565_tile_untiler_unit_macros.svh"

module rgb565_tile_untiler_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rtu_pkg::PIX_W-1:0]     pixel_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rtu_pkg::POS_W-1:0]     column,
	output logic [rtu_pkg::POS_W-1:0]     row,
	output logic [rtu_pkg::CH_W-1:0]      red,
	output logic [rtu_pkg::CH_W-1:0]      green,
	output logic [rtu_pkg::CH_W-1:0]      blue,
	output logic                          last_pixel,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rtu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rtu_pkg::DIM_W-1:0]     cfg_data
);
	import rtu_pkg::*;

	dims_t dims;
	pos_t  cur;

	logic             valid_s1, valid_s2, adv_s1;
	logic [PIX_W-1:0] word_s1;
	logic [POS_W-1:0] column_s2, row_s2;
	logic [CH_W-1:0]  red_s2, green_s2, blue_s2;
	logic             last_s2;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || !valid_s2 || out_ready;

	rtu_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.dims     (dims)
	);

	rtu_pos u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv_s1),
		.dims   (dims),
		.cur    (cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= pixel_word;
		end
		if (adv_s1) begin
			column_s2 <= cur.column;
			row_s2    <= cur.row;
			red_s2    <= expand5(word_s1[15:11]);
			green_s2  <= expand6(word_s1[10:5]);
			blue_s2   <= expand5(word_s1[4:0]);
			last_s2   <= cur.last;
		end
	end

	assign out_valid  = valid_s2;
	assign column     = column_s2;
	assign row        = row_s2;
	assign red        = red_s2;
	assign green      = green_s2;
	assign blue       = blue_s2;
	assign last_pixel = last_s2;

	`RTU_CHECK_SAME(a_stall_only_when_full, !in_ready, valid_s1 && valid_s2 && !out_ready, "input stalled without a full pipeline")
	`RTU_CHECK_NEXT(a_adv_fills_result, adv_s1, valid_s2, "advanced request missing from result register")
	`RTU_CHECK_NEXT(a_wrap_after_last, adv_s1 && cur.last, cur.column == '0 && cur.row == '0, "counters did not wrap after final pixel")

endmodule
